// File: design/kmsc_pkg.sv
// kmsc_pkg: shared types, constants and helper functions of the keypad motor speed controller
// no dependencies; imported by every module of the block
package kmsc_pkg;

  // field and register widths
  localparam int SampleBits  = 12;
  localparam int DutyBits    = 12;
  localparam int CfgBits     = 12;
  localparam int PctBits     = 7;
  localparam int DigitBits   = 4;
  localparam int KeyBits     = 4;
  localparam int CmdBits     = 2;
  localparam int LineBits    = 4;
  localparam int ApbDataBits = 32;
  localparam int CfgAddrBits = 3;
  localparam int TargetSlots = 4;
  localparam int DutyKeys    = 10;

  // register reset values
  localparam logic [CfgBits-1:0] AdcFullSpeedReset = 12'd4095;
  localparam logic [CfgBits-1:0] PwmPeriodReset    = 12'd800;
  localparam logic [DutyBits-1:0] DutyMax          = 12'd4095;

  // speed loop
  localparam logic signed [SampleBits:0] Deadband = 13'sd5;

  // counter digit
  localparam logic [DigitBits-1:0] DigitMax = 4'd9;

  // item commands
  typedef enum logic [CmdBits-1:0] {
    CmdPress  = 2'd0,
    CmdSample = 2'd1,
    CmdTick   = 2'd2
  } kmsc_cmd_e;

  // configuration register index
  typedef enum logic [0:0] {
    RegAdcFullSpeed = 1'b0,
    RegPwmPeriod    = 1'b1
  } kmsc_reg_e;

  // special keys
  localparam logic [KeyBits-1:0] KeyTargetFirst = 4'h1;
  localparam logic [KeyBits-1:0] KeyTargetLast  = 4'h4;
  localparam logic [KeyBits-1:0] KeyDigitLast   = 4'h9;
  localparam logic [KeyBits-1:0] KeyA           = 4'hA;
  localparam logic [KeyBits-1:0] KeyB           = 4'hB;
  localparam logic [KeyBits-1:0] KeyC           = 4'hC;
  localparam logic [KeyBits-1:0] KeyD           = 4'hD;
  localparam logic [KeyBits-1:0] KeyE           = 4'hE;
  localparam logic [KeyBits-1:0] KeyF           = 4'hF;

  // keypad layout, index is {row, column}
  localparam logic [KeyBits-1:0] KeyTable [16] = '{
    4'h1, 4'h2, 4'h3, 4'hA,
    4'h4, 4'h5, 4'h6, 4'hB,
    4'h7, 4'h8, 4'h9, 4'hC,
    4'hE, 4'h0, 4'hF, 4'hD
  };

  // target percent for each target slot
  localparam logic [PctBits-1:0] PctTable [TargetSlots] = '{
    7'd50, 7'd60, 7'd70, 7'd80
  };

  typedef struct packed {
    logic [CmdBits-1:0]    command;
    logic [LineBits-1:0]   key_row_lines;
    logic [LineBits-1:0]   key_column_lines;
    logic [SampleBits-1:0] speed_sample;
  } kmsc_in_t;

  typedef struct packed {
    logic [DutyBits-1:0]  duty_compare;
    logic [DigitBits-1:0] count_digit;
    logic                 speed_mode;
    logic                 count_running;
    logic                 count_upward;
    logic [PctBits-1:0]   target_percent;
    logic [KeyBits-1:0]   key_code;
    logic                 key_valid;
  } kmsc_out_t;

  typedef struct packed {
    logic                 mode_speed;
    logic                 counter_enabled;
    logic                 direction_up;
    logic [DigitBits-1:0] digit;
    logic [1:0]           target_sel;
    logic [DutyBits-1:0]  duty;
  } kmsc_state_t;

  // values derived from the configuration registers at write time
  typedef struct packed {
    logic [TargetSlots-1:0][SampleBits-1:0] target_tab;
    logic [DutyKeys-1:0][DutyBits-1:0]      duty_tab;
    logic [DutyBits-1:0]                    duty_top;
  } kmsc_cal_t;

  // floor(x/10) by reciprocal multiply, exact over the range used here
  function automatic logic [11:0] div10(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd52429;
    return prod[30:19];
  endfunction

  // highest active line picks the table index, line 3 gives 0
  function automatic logic [1:0] line_index(input logic [LineBits-1:0] lines);
    logic [1:0] idx;
    if (lines[3]) begin
      idx = 2'd0;
    end else if (lines[2]) begin
      idx = 2'd1;
    end else if (lines[1]) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    return idx;
  endfunction

  // floor(pct*adc/100) with pct = 50 + 10*sel
  function automatic logic [SampleBits-1:0] target_of(input logic [1:0] sel,
                                                      input logic [CfgBits-1:0] adc);
    logic [15:0] prod;
    prod = (16'(sel) + 16'd5) * 16'(adc);
    return div10(prod);
  endfunction

  // floor(key*period/10)
  function automatic logic [DutyBits-1:0] duty_of(input logic [KeyBits-1:0] key,
                                                  input logic [CfgBits-1:0] period);
    logic [15:0] prod;
    prod = 16'(key) * 16'(period);
    return div10(prod);
  endfunction

  // period plus one, saturated
  function automatic logic [DutyBits-1:0] top_of(input logic [CfgBits-1:0] period);
    logic [DutyBits-1:0] top;
    if (period == DutyMax) begin
      top = DutyMax;
    end else begin
      top = period + 12'd1;
    end
    return top;
  endfunction

endpackage

// File: design/keypad_motor_speed_controller_unit.sv
// keypad_motor_speed_controller_unit: top level with input stage, state, result stage and APB regs
// depends on kmsc_pkg and kmsc_step
//
// usage
// - input channel (in_valid_i/in_ready_o/in_item_i): one transfer per item, a keypad
//   press, a tachometer sample or a counter tick
// - output channel (out_valid_o/out_ready_i/out_item_o): exactly one result per item,
//   in item order, showing the state after that item and the key it decoded
// - a result is presented at the clock edge right after its input transfer when the
//   output side is not stalled
// - throughput: one item per cycle while the output side is not stalled; it is set by
//   the state update between the input register and the result register, since each
//   item reads the state that the item before it left
// - when the receiver stalls, the result register holds, the input register still
//   takes one more item, and in_ready_o drops only when both are full
// - APB registers: adc_full_speed at 0x0, pwm_period at 0x4; a write also refreshes
//   the derived target and duty tables, so they are ready for the next item
// - reset: asynchronous, active low; both stages empty, duty mode, counter stopped,
//   counting up, digit 0, target 50 percent, duty 0, registers at their defaults
module keypad_motor_speed_controller_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  kmsc_pkg::kmsc_in_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output kmsc_pkg::kmsc_out_t                  out_item_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kmsc_pkg::CfgAddrBits-1:0]     paddr,
  input  logic [kmsc_pkg::ApbDataBits-1:0]     pwdata,
  output logic [kmsc_pkg::ApbDataBits-1:0]     prdata,
  output logic                                 pready
);
  import kmsc_pkg::*;

  // configuration registers and the tables derived from them
  logic [CfgBits-1:0] adc_q;
  logic [CfgBits-1:0] period_q;
  kmsc_cal_t          cal_q;
  kmsc_cal_t          cal_d;
  logic [CfgBits-1:0] adc_d;
  logic [CfgBits-1:0] period_d;
  logic               cfg_wr;
  kmsc_reg_e          reg_idx;

  // pipeline
  logic        in_vld_q, in_vld_d;
  kmsc_in_t    in_q;
  logic        out_vld_q, out_vld_d;
  kmsc_out_t   out_q, out_d;
  logic        advance;
  logic        in_xfer;

  // architectural state
  kmsc_state_t state_q, state_d;
  logic [KeyBits-1:0] key_code;
  logic               key_valid;

  // ---------------------------------------------------------------------------
  // APB port, always ready, write lands in the access phase
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = kmsc_reg_e'(paddr[CfgAddrBits-1]);

  always_comb begin
    case (reg_idx)
      RegAdcFullSpeed: prdata = ApbDataBits'(adc_q);
      RegPwmPeriod:    prdata = ApbDataBits'(period_q);
      default:         prdata = '0;
    endcase
  end

  // new register values and their derived tables, computed from pwdata
  always_comb begin
    adc_d    = adc_q;
    period_d = period_q;
    cal_d    = cal_q;
    if (cfg_wr) begin
      case (reg_idx)
        RegAdcFullSpeed: begin
          adc_d = pwdata[CfgBits-1:0];
          for (int i = 0; i < TargetSlots; i++) begin
            cal_d.target_tab[i] = target_of(2'(i), pwdata[CfgBits-1:0]);
          end
        end
        RegPwmPeriod: begin
          period_d = pwdata[CfgBits-1:0];
          for (int k = 0; k < DutyKeys; k++) begin
            cal_d.duty_tab[k] = duty_of(KeyBits'(k), pwdata[CfgBits-1:0]);
          end
          cal_d.duty_top = top_of(pwdata[CfgBits-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_q    <= AdcFullSpeedReset;
      period_q <= PwmPeriodReset;
      for (int i = 0; i < TargetSlots; i++) begin
        cal_q.target_tab[i] <= target_of(2'(i), AdcFullSpeedReset);
      end
      for (int k = 0; k < DutyKeys; k++) begin
        cal_q.duty_tab[k] <= duty_of(KeyBits'(k), PwmPeriodReset);
      end
      cal_q.duty_top <= top_of(PwmPeriodReset);
    end else begin
      adc_q    <= adc_d;
      period_q <= period_d;
      cal_q    <= cal_d;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: input register feeds the result register through one step
  // ---------------------------------------------------------------------------
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // next state for the item in the input register
  kmsc_step u_step (
    .state_i     (state_q),
    .item_i      (in_q),
    .cal_i       (cal_q),
    .state_o     (state_d),
    .key_code_o  (key_code),
    .key_valid_o (key_valid)
  );

  // result shows the state after the item
  always_comb begin
    out_d.duty_compare   = state_d.duty;
    out_d.count_digit    = state_d.digit;
    out_d.speed_mode     = state_d.mode_speed;
    out_d.count_running  = state_d.counter_enabled;
    out_d.count_upward   = state_d.direction_up;
    out_d.target_percent = PctTable[state_d.target_sel];
    out_d.key_code       = key_code;
    out_d.key_valid      = key_valid;
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q                <= 1'b0;
      out_vld_q               <= 1'b0;
      state_q.mode_speed      <= 1'b0;
      state_q.counter_enabled <= 1'b0;
      state_q.direction_up    <= 1'b1;
      state_q.digit           <= '0;
      state_q.target_sel      <= '0;
      state_q.duty            <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// File: design/kmsc_step.sv
// kmsc_step: next-state logic for one item (key decode, speed loop, digit counter)
// depends on kmsc_pkg
module kmsc_step (
  input  kmsc_pkg::kmsc_state_t      state_i,
  input  kmsc_pkg::kmsc_in_t         item_i,
  input  kmsc_pkg::kmsc_cal_t        cal_i,
  output kmsc_pkg::kmsc_state_t      state_o,
  output logic [kmsc_pkg::KeyBits-1:0] key_code_o,
  output logic                       key_valid_o
);
  import kmsc_pkg::*;

  logic [KeyBits-1:0]           key;
  logic                         press_hit;
  logic [SampleBits-1:0]        target;
  logic signed [SampleBits:0]   err;
  logic [SampleBits-1:0]        err_mag;
  logic [DutyBits-1:0]          step;
  logic [DutyBits:0]            raised;
  kmsc_state_t                  st;

  assign press_hit = (item_i.key_row_lines != '0) && (item_i.key_column_lines != '0);
  assign key = KeyTable[{line_index(item_i.key_row_lines),
                         line_index(item_i.key_column_lines)}];

  // speed error and its tenth
  assign target  = cal_i.target_tab[state_i.target_sel];
  assign err     = $signed({1'b0, target}) - $signed({1'b0, item_i.speed_sample});
  assign err_mag = err[SampleBits] ? SampleBits'(-err) : err[SampleBits-1:0];
  assign step    = div10(16'(err_mag));
  assign raised  = {1'b0, state_i.duty} + {1'b0, step};

  always_comb begin
    st          = state_i;
    key_code_o  = '0;
    key_valid_o = 1'b0;
    case (item_i.command)
      CmdPress: begin
        if (press_hit) begin
          key_code_o  = key;
          key_valid_o = 1'b1;
          case (key)
            KeyB, KeyC: ;
            KeyD: st.mode_speed      = ~state_i.mode_speed;
            KeyE: st.counter_enabled = ~state_i.counter_enabled;
            KeyF: st.direction_up    = ~state_i.direction_up;
            KeyA: begin
              if (!state_i.mode_speed) begin
                st.duty = cal_i.duty_top;
              end
            end
            default: begin
              if (state_i.mode_speed) begin
                if (key >= KeyTargetFirst && key <= KeyTargetLast) begin
                  st.target_sel = 2'(key - KeyTargetFirst);
                end
              end else if (key <= KeyDigitLast) begin
                st.duty = cal_i.duty_tab[key];
              end
            end
          endcase
        end
      end
      CmdSample: begin
        if (state_i.mode_speed) begin
          if (err > Deadband && state_i.duty < cal_i.duty_top) begin
            st.duty = (raised > {1'b0, cal_i.duty_top}) ? cal_i.duty_top
                                                       : raised[DutyBits-1:0];
          end else if (err < -Deadband && state_i.duty != '0) begin
            st.duty = (step >= state_i.duty) ? '0 : state_i.duty - step;
          end
        end
      end
      CmdTick: begin
        if (state_i.counter_enabled) begin
          if (state_i.direction_up) begin
            st.digit = (state_i.digit >= DigitMax) ? '0 : state_i.digit + 4'd1;
          end else begin
            st.digit = (state_i.digit == '0) ? DigitMax : state_i.digit - 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign state_o = st;

endmodule

// File: design/kmsc_checker.sv
// kmsc_checker: port-level assertions for the keypad motor speed controller, bound to the top
// depends on kmsc_pkg and keypad_motor_speed_controller_unit
module kmsc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input kmsc_pkg::kmsc_out_t out_item_o
);
  import kmsc_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // every input transfer is followed by a valid result, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no result after input transfer");

  // input side only backs up when the output side is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // a result without a decoded key carries key code zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.key_valid |-> out_item_o.key_code == '0)
    else $error("key code set without a decoded key");

endmodule

bind keypad_motor_speed_controller_unit kmsc_checker u_kmsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// File: tb/sv/tb_keypad_motor_speed_controller_unit.sv
// tb_keypad_motor_speed_controller_unit: self-checking bench for the keypad motor speed controller
// runs a directed list and then random keypad, tachometer and tick items through the dut
// depends on kmsc_pkg and keypad_motor_speed_controller_unit
module tb_keypad_motor_speed_controller_unit;
  import kmsc_pkg::*;

  // command code the block has no use for, must leave the state alone
  localparam logic [CmdBits-1:0] CmdUnused = 2'd3;
  localparam int PhaseCount = 6;
  localparam int ItemsPerPhase = 235;
  localparam int ShownMismatches = 100;

  // keypad layout as {row slot, column slot}, slot 0 is the highest line
  localparam logic [KeyBits-1:0] KeypadLayout [16] = '{
    4'h1, 4'h2, 4'h3, 4'hA,
    4'h4, 4'h5, 4'h6, 4'hB,
    4'h7, 4'h8, 4'h9, 4'hC,
    4'hE, 4'h0, 4'hF, 4'hD
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // item channel
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  kmsc_in_t in_item_i = '0;

  // status channel
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  kmsc_out_t out_item_o;

  // register port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [ApbDataBits-1:0] pwdata = '0;
  logic [ApbDataBits-1:0] prdata;
  logic pready;

  // pending items for the driver and the status words still owed by the dut
  kmsc_in_t command_q[$];
  kmsc_out_t status_due_q[$];

  // idle percentages of sender and receiver for the current phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned status_seen = 0;

  // shadow of the register file
  int unsigned cfg_adc = 4095;
  int unsigned cfg_period = 800;

  // shadow of the controller state, reset values
  logic speed_on = 1'b0;
  logic count_on = 1'b0;
  logic count_up = 1'b1;
  int unsigned digit_now = 0;
  int unsigned pct_now = 50;
  int unsigned duty_now = 0;

  keypad_motor_speed_controller_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the dut hangs a handshake
  initial begin
    #2000000;
    $display("keypad_motor_speed_controller_unit verification failed");
    $finish;
  end

  // slot of the highest active line, top line gives slot 0
  function automatic logic [1:0] line_slot(logic [LineBits-1:0] lines);
    logic [1:0] slot;
    slot = 2'd3;
    for (int b = 0; b < LineBits; b++) begin
      if (lines[b]) begin
        slot = 2'(3 - b);
      end
    end
    return slot;
  endfunction

  // advances the shadow state by one item and returns the status word it must produce
  function automatic kmsc_out_t status_after_item(kmsc_in_t it);
    kmsc_out_t st;
    logic [KeyBits-1:0] key;
    logic hit;
    int unsigned duty_top;
    int unsigned target;
    int unsigned step;
    int err;
    duty_top = (cfg_period + 1 > 4095) ? 4095 : cfg_period + 1;
    key = '0;
    hit = 1'b0;
    case (it.command)
      CmdPress: begin
        // a press with no row or no column line is dropped
        if (it.key_row_lines != '0 && it.key_column_lines != '0) begin
          key = KeypadLayout[{line_slot(it.key_row_lines), line_slot(it.key_column_lines)}];
          hit = 1'b1;
          case (key)
            KeyB, KeyC: begin
            end
            KeyD: begin
              speed_on = ~speed_on;
            end
            KeyE: begin
              count_on = ~count_on;
            end
            KeyF: begin
              count_up = ~count_up;
            end
            default: begin
              if (speed_on) begin
                if (key >= KeyTargetFirst && key <= KeyTargetLast) begin
                  pct_now = 40 + 10 * int'(key);
                end
              end else if (key == KeyA) begin
                duty_now = duty_top;
              end else begin
                duty_now = (int'(key) * cfg_period) / 10;
              end
            end
          endcase
        end
      end
      CmdSample: begin
        target = (pct_now * cfg_adc) / 100;
        err = int'(target) - int'(it.speed_sample);
        // deadband of 5 either side, a duty already above top is never raised
        if (speed_on) begin
          if (err > 5 && duty_now < duty_top) begin
            step = err / 10;
            duty_now = (duty_now + step > duty_top) ? duty_top : duty_now + step;
          end else if (err < -5 && duty_now > 0) begin
            step = (-err) / 10;
            duty_now = (step >= duty_now) ? 0 : duty_now - step;
          end
        end
      end
      CmdTick: begin
        if (count_on) begin
          if (count_up) begin
            digit_now = (digit_now >= 9) ? 0 : digit_now + 1;
          end else begin
            digit_now = (digit_now == 0) ? 9 : digit_now - 1;
          end
        end
      end
      default: begin
      end
    endcase
    st.duty_compare = DutyBits'(duty_now);
    st.count_digit = DigitBits'(digit_now);
    st.speed_mode = speed_on;
    st.count_running = count_on;
    st.count_upward = count_up;
    st.target_percent = PctBits'(pct_now);
    st.key_code = key;
    st.key_valid = hit;
    return st;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= ShownMismatches) begin
      $display("%0t: status %0d: %s", $realtime, status_seen, msg);
    end
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // driver: keeps valid and payload steady until the transfer, predicts on every transfer
  always @(posedge clk_i) begin : drive_items
    kmsc_in_t nxt_item;
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_item = in_item_i;
      if (in_valid_i && in_ready_o) begin
        status_due_q.push_back(status_after_item(in_item_i));
        nxt_valid = 1'b0;
      end
      // a new item may follow the accepted one in the very next cycle
      if (!nxt_valid && command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_item = command_q.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid_i <= nxt_valid;
      in_item_i <= nxt_item;
    end
  end

  // monitor: random back-pressure, every status transfer checked against the oldest prediction
  always @(posedge clk_i) begin : watch_status
    kmsc_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        status_seen++;
        if (status_due_q.size() == 0) begin
          report_mismatch("status transfer with no item outstanding");
        end else begin
          want = status_due_q.pop_front();
          check_field("duty_compare", 32'(out_item_o.duty_compare), 32'(want.duty_compare));
          check_field("count_digit", 32'(out_item_o.count_digit), 32'(want.count_digit));
          check_field("speed_mode", 32'(out_item_o.speed_mode), 32'(want.speed_mode));
          check_field("count_running", 32'(out_item_o.count_running),
                      32'(want.count_running));
          check_field("count_upward", 32'(out_item_o.count_upward), 32'(want.count_upward));
          check_field("target_percent", 32'(out_item_o.target_percent),
                      32'(want.target_percent));
          check_field("key_code", 32'(out_item_o.key_code), 32'(want.key_code));
          check_field("key_valid", 32'(out_item_o.key_valid), 32'(want.key_valid));
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic kmsc_in_t make_item(logic [CmdBits-1:0] cmd, logic [LineBits-1:0] rows,
                                         logic [LineBits-1:0] cols,
                                         logic [SampleBits-1:0] sample);
    kmsc_in_t it;
    it.command = cmd;
    it.key_row_lines = rows;
    it.key_column_lines = cols;
    it.speed_sample = sample;
    return it;
  endfunction

  // random line pattern with its highest line picked evenly, lower lines random
  function automatic logic [LineBits-1:0] random_lines();
    int unsigned b;
    b = $urandom_range(LineBits - 1);
    return LineBits'((1 << b) | ($urandom & ((1 << b) - 1)));
  endfunction

  // random mix: presses, samples (half near a target), ticks and a few unused commands
  task automatic queue_random_items(int unsigned n);
    kmsc_in_t it;
    int unsigned roll;
    int near;
    repeat (n) begin
      roll = $urandom_range(99);
      it.key_row_lines = LineBits'($urandom);
      it.key_column_lines = LineBits'($urandom);
      it.speed_sample = SampleBits'($urandom);
      if (roll < 35) begin
        it.command = CmdPress;
        if ($urandom_range(9) != 0) begin
          it.key_row_lines = random_lines();
          it.key_column_lines = random_lines();
        end else if ($urandom_range(1) != 0) begin
          it.key_row_lines = '0;
        end else begin
          it.key_column_lines = '0;
        end
      end else if (roll < 75) begin
        it.command = CmdSample;
        if ($urandom_range(1) != 0) begin
          // land around the target so the deadband and small steps get exercised
          near = int'(((50 + 10 * $urandom_range(3)) * cfg_adc) / 100);
          near = near + int'($urandom_range(40)) - 20;
          near = (near < 0) ? 0 : (near > 4095) ? 4095 : near;
          it.speed_sample = SampleBits'(near);
        end
      end else if (roll < 95) begin
        it.command = CmdTick;
      end else begin
        it.command = CmdUnused;
      end
      command_q.push_back(it);
    end
  endtask

  // sender holds off until every item is through and every status has come back
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (command_q.size() != 0 || in_valid_i || status_due_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access cycle, register taken at the end of access
  task automatic write_register(kmsc_reg_e which, int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= ApbDataBits'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == RegAdcFullSpeed) begin
      cfg_adc = value & 12'hFFF;
    end else begin
      cfg_period = value & 12'hFFF;
    end
  endtask

  initial begin : run_phases
    int unsigned phase_adc [PhaseCount];
    int unsigned phase_period [PhaseCount];
    // register settings per phase: defaults, zero and tiny period, full speed at maximum
    // with period 4000, zero period, period past the top, then a random pair
    phase_adc = '{4095, 0, 4095, 2000, 1234, 0};
    phase_period = '{800, 1, 4000, 0, 4095, 0};
    phase_adc[PhaseCount - 1] = $urandom_range(4095);
    phase_period[PhaseCount - 1] = $urandom_range(4000, 1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PhaseCount; p++) begin
      // idling: sender light and receiver heavy, then swapped, then none at all
      if (p < 2) begin
        send_idle_pct = 32;
        stall_pct = 49;
      end else if (p < 4) begin
        send_idle_pct = 49;
        stall_pct = 32;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      // block is idle here: all status words of the previous phase are in
      write_register(RegAdcFullSpeed, phase_adc[p]);
      write_register(RegPwmPeriod, phase_period[p]);

      if (p == 0) begin
        // directed list, period 800 and full speed 4095
        command_q.push_back(make_item(CmdPress, 4'h0, 4'hF, 12'h000));   // no row line
        command_q.push_back(make_item(CmdPress, 4'hF, 4'h0, 12'hFFF));   // no column line
        command_q.push_back(make_item(CmdPress, 4'hF, 4'hF, 12'h000));   // highest lines win, 1
        command_q.push_back(make_item(CmdPress, 4'h2, 4'h2, 12'h000));   // key 9
        command_q.push_back(make_item(CmdPress, 4'h1, 4'h4, 12'h000));   // key 0, duty zero
        command_q.push_back(make_item(CmdPress, 4'h8, 4'h1, 12'h000));   // key A, duty at top
        command_q.push_back(make_item(CmdPress, 4'h4, 4'h1, 12'h000));   // key B, no effect
        command_q.push_back(make_item(CmdPress, 4'h2, 4'h1, 12'h000));   // key C, no effect
        command_q.push_back(make_item(CmdTick, 4'h0, 4'h0, 12'h000));    // counter stopped
        command_q.push_back(make_item(CmdPress, 4'h1, 4'h8, 12'h000));   // key E, count on
        command_q.push_back(make_item(CmdTick, 4'hF, 4'hF, 12'hFFF));
        command_q.push_back(make_item(CmdPress, 4'h1, 4'h2, 12'h000));   // key F, count down
        command_q.push_back(make_item(CmdTick, 4'h0, 4'h0, 12'h000));
        command_q.push_back(make_item(CmdTick, 4'h0, 4'h0, 12'h000));    // wraps below zero
        command_q.push_back(make_item(CmdPress, 4'h1, 4'h1, 12'h000));   // key D, speed mode
        command_q.push_back(make_item(CmdPress, 4'h4, 4'h8, 12'h000));   // key 4, target 80
        command_q.push_back(make_item(CmdSample, 4'h0, 4'h0, 12'h000));  // duty already at top
        command_q.push_back(make_item(CmdSample, 4'h0, 4'h0, 12'hFFF));  // large negative error
        command_q.push_back(make_item(CmdPress, 4'h8, 4'h8, 12'h000));   // key 1, target 50
        command_q.push_back(make_item(CmdSample, 4'h0, 4'h0, 12'd2042)); // inside deadband
        command_q.push_back(make_item(CmdSample, 4'h0, 4'h0, 12'd2041)); // just out, zero step
        command_q.push_back(make_item(CmdSample, 4'h0, 4'h0, 12'h000));  // clamps to top
        command_q.push_back(make_item(CmdPress, 4'h4, 4'h4, 12'h000));   // key 5 ignored here
        command_q.push_back(make_item(CmdUnused, 4'hF, 4'hF, 12'hFFF));  // no state change
        command_q.push_back(make_item(CmdPress, 4'h1, 4'h1, 12'h000));   // key D, duty mode
      end
      queue_random_items(ItemsPerPhase);
      wait_drained();
    end

    // let any stray status transfer show up before the verdict
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("keypad_motor_speed_controller_unit verification clean");
    end else begin
      $display("keypad_motor_speed_controller_unit verification failed");
    end
    $finish;
  end

endmodule
